[rtl/core/fp_int_convert_saturating_top_defines.svh]
// Assertion macros for the conversion unit.
`ifndef FP_INT_CONVERT_SATURATING_TOP_DEFINES_SVH
`define FP_INT_CONVERT_SATURATING_TOP_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define FIC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Stalled output must not change.
`define FIC_ASSERT_HOLD(label, vld, rdy, data, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (vld && !rdy) |=> (vld && $stable(data))) else $error(msg);

`endif

[rtl/core/fic_pkg.sv]
//------------------------------------------------------------------------------
// fic_pkg
// Shared types and opcodes for the float/integer conversion pipeline.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package fic_pkg;

    localparam logic [2:0] OP_D2U = 3'd0;
    localparam logic [2:0] OP_D2S = 3'd1;
    localparam logic [2:0] OP_S2D = 3'd2;
    localparam logic [2:0] OP_U2D = 3'd3;
    localparam logic [2:0] OP_S2F = 3'd4;
    localparam logic [2:0] OP_U2F = 3'd5;

    // Stage 1 to stage 2: decoded operand.
    typedef struct packed {
        logic [2:0]  opcode;
        logic        to_int;
        logic        neg;
        logic [63:0] mag;     // integer magnitude or double mantissa
        logic [11:0] exp_u;   // unbiased double exponent for to_int, signed
        logic        nan;
        logic        is_dbl;  // integer to binary64
    } s1_t;

    // Stage 2 to stage 3.
    typedef struct packed {
        logic [2:0]  opcode;
        logic        to_int;
        logic        neg;
        logic [63:0] val;     // truncated magnitude or normalized integer
        logic [6:0]  p;       // leading one position
        logic        zero;
        logic        sat;     // to_int: special result
        logic [63:0] sat_val;
        logic        is_dbl;
    } s2_t;

endpackage

[rtl/core/fic_decode.sv]
//------------------------------------------------------------------------------
// fic_decode
// Stage one: splits the operand into sign, exponent and magnitude.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module fic_decode (
    input  logic [2:0]    opcode,
    input  logic [63:0]   operand_bits,
    output fic_pkg::s1_t  dec
);
    import fic_pkg::*;

    logic [10:0] e;
    logic [51:0] f;

    always_comb
    begin
        e = operand_bits[62:52];
        f = operand_bits[51:0];
        dec = '0;
        dec.opcode = opcode;
        dec.to_int = (opcode == OP_D2U) || (opcode == OP_D2S);
        dec.is_dbl = (opcode == OP_S2D) || (opcode == OP_U2D);
        dec.nan = (e == 11'h7FF) && (f != '0);
        if (dec.to_int)
        begin
            dec.neg = operand_bits[63];
            if (e == 11'd0)
            begin
                dec.exp_u = 12'hF00;   // below one
                dec.mag = '0;
            end
            else if (e == 11'h7FF)
            begin
                dec.exp_u = 12'd1000;  // infinity
                dec.mag = '0;
            end
            else
            begin
                dec.exp_u = {1'b0, e} - 12'd1023;
                dec.mag = {11'd0, 1'b1, f};
            end
        end
        else if ((opcode == OP_S2D) || (opcode == OP_S2F))
        begin
            dec.neg = operand_bits[63];
            dec.mag = operand_bits[63] ? (64'd0 - operand_bits) : operand_bits;
        end
        else
        begin
            dec.mag = operand_bits;
        end
    end
endmodule

[rtl/core/fic_shift.sv]
//------------------------------------------------------------------------------
// fic_shift
// Stage two: truncating shift for float to integer, normalization for
// integer to float.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module fic_shift (
    input  fic_pkg::s1_t  dec,
    output fic_pkg::s2_t  sh
);
    import fic_pkg::*;

    logic [6:0] lz;
    logic       found;
    logic [5:0] s;

    always_comb
    begin
        lz = 7'd0;
        found = 1'b0;
        for (int i = 63; i >= 0; i--)
        begin
            if (!found && dec.mag[i])
            begin
                found = 1'b1;
                lz = 7'(i);
            end
        end
        sh = '0;
        sh.opcode = dec.opcode;
        sh.to_int = dec.to_int;
        sh.neg = dec.neg;
        sh.is_dbl = dec.is_dbl;
        s = '0;
        if (dec.to_int)
        begin
            if (dec.nan || $signed(dec.exp_u) < 0)
            begin
                sh.sat = 1'b1;
                sh.sat_val = '0;
            end
            else if (dec.opcode == OP_D2U)
            begin
                if (dec.neg)
                begin
                    sh.sat = 1'b1;
                    sh.sat_val = '0;
                end
                else if ($signed(dec.exp_u) >= 64)
                begin
                    sh.sat = 1'b1;
                    sh.sat_val = '1;
                end
            end
            else if ($signed(dec.exp_u) >= 63)
            begin
                sh.sat = 1'b1;
                sh.sat_val = dec.neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            end
            if (dec.exp_u[5:0] >= 6'd52)
                sh.val = dec.mag << (dec.exp_u[5:0] - 6'd52);
            else
                sh.val = dec.mag >> (6'd52 - dec.exp_u[5:0]);
        end
        else
        begin
            sh.zero = !found;
            sh.p = lz;
            s = 6'(7'd63 - lz);
            sh.val = dec.mag << s;   // leading one at bit 63
        end
    end
endmodule

[rtl/core/fic_round.sv]
//------------------------------------------------------------------------------
// fic_round
// Stage three: sign fix for integers, round to nearest even and pack for
// floats.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module fic_round (
    input  fic_pkg::s2_t  sh,
    output logic [63:0]   result_bits
);
    import fic_pkg::*;

    logic [53:0] kd;
    logic        rd;
    logic [24:0] kf;
    logic        rf;
    logic [10:0] ed;
    logic [7:0]  ef;

    always_comb
    begin
        // Double: keep bits 63:11, guard bit 10, sticky below.
        rd = sh.val[10] && ((sh.val[9:0] != '0) || sh.val[11]);
        kd = {1'b0, sh.val[63:11]} + {53'd0, rd};
        ed = 11'(sh.p) + 11'd1023 + {10'd0, kd[53]};
        // Single: keep bits 63:40.
        rf = sh.val[39] && ((sh.val[38:0] != '0) || sh.val[40]);
        kf = {1'b0, sh.val[63:40]} + {24'd0, rf};
        ef = 8'(sh.p) + 8'd127 + {7'd0, kf[24]};
        result_bits = '0;
        if (sh.to_int)
        begin
            if (sh.sat)
                result_bits = sh.sat_val;
            else
                result_bits = sh.neg ? (64'd0 - sh.val) : sh.val;
        end
        else if (sh.zero)
            result_bits = '0;
        else if (sh.is_dbl)
            result_bits = {sh.neg, ed, kd[53] ? kd[52:1] : kd[51:0]};
        else if ((sh.opcode == OP_S2F) || (sh.opcode == OP_U2F))
            result_bits = {32'd0, sh.neg, ef, kf[24] ? kf[23:1] : kf[22:0]};
    end
endmodule

[rtl/core/fp_int_convert_saturating_top.sv]
//------------------------------------------------------------------------------
// fp_int_convert_saturating_top
// Saturating binary64/binary32 and 64-bit integer conversion pipeline.
//------------------------------------------------------------------------------
//  channel | signals                        | accepted when
//  in      | valid, ready, opcode, operand  | valid && ready
//  out     | out_valid, out_ready, result   | out_valid && out_ready
//
// Three register stages: decode, shift, round/pack.
// One item is accepted every cycle unless the output stalls.
// Reset clears all valid bits; payload registers are not reset.
// A stall on the output holds every full stage whose later stages are all full.
`timescale 1ns / 1ps
`include "fp_int_convert_saturating_top_defines.svh"
module fp_int_convert_saturating_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        ready,
    input  logic [2:0]  opcode,
    input  logic [63:0] operand_bits,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_bits
);
    import fic_pkg::*;

    s1_t         dec;
    s1_t         s1_reg;
    s2_t         sh;
    s2_t         s2_reg;
    logic [63:0] res;
    logic [63:0] out_reg;
    logic        v1_reg, v2_reg, v3_reg;
    logic        en1, en2, en3;

    fic_decode u_dec (.opcode(opcode), .operand_bits(operand_bits), .dec(dec));
    fic_shift  u_sh  (.dec(s1_reg), .sh(sh));
    fic_round  u_rnd (.sh(s2_reg), .result_bits(res));

    assign en3 = !v3_reg || out_ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign ready = en1;
    assign out_valid = v3_reg;
    assign result_bits = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
            s1_reg <= dec;
        if (en2)
            s2_reg <= sh;
        if (en3)
            out_reg <= res;
    end

    `FIC_ASSERT_HOLD(a_out_hold, out_valid, out_ready, result_bits, "output changed in stall")
    `FIC_ASSERT(a_ready_free, (!v3_reg) |-> ready, "not ready while output empty")
    `FIC_ASSERT(a_adv, (v2_reg && en3) |=> v3_reg, "item lost between stages")
endmodule
